/* hdl/rfbe_pkg.sv */
// Shared types and constants of the RNS fast base extension block.
// No dependencies; used by rns_fast_base_extension and its testbench.
`timescale 1ns / 1ps
package rfbe_pkg;

   localparam int DATA_W      = 60;              // residue and table word field
   localparam int IDX_W       = 3;               // limb index fields
   localparam int OP_W        = 3;
   localparam int BIT_W       = $clog2(DATA_W);  // bit counter of one serial pass
   localparam int REQ_TDATA_W = 72;              // op, source_index, target_index, value
   localparam int RSP_TDATA_W = 64;              // target_limb, residue

   typedef enum logic [OP_W-1:0] {
      OP_RESIDUE  = 3'd0,
      OP_SRC_MOD  = 3'd1,
      OP_TGT_MOD  = 3'd2,
      OP_QHAT_INV = 3'd3,
      OP_QHAT_TGT = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRC_RED,
      ST_SRC_MUL,
      ST_TGT_RED,
      ST_TGT_MUL,
      ST_ACC_RED,
      ST_ACC_ADD,
      ST_FINISH
   } state_type;

endpackage

/* hdl/rfbe_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing but the timescale; holds the qHat-mod-target table.
`timescale 1ns / 1ps
module rfbe_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/rns_fast_base_extension.sv */
// Channel   Dir  Handshake            Payload
// req_      in   req_tvalid/tready    tdata: op, source_index, target_index, value; tlast: last
// rsp_      out  rsp_tvalid/tready    tdata: target_limb, residue; tlast: last_res
//
// A residue is processed by the single bit-serial modular multiply and reduce unit, which
// handles one bit of a 60-bit operand per cycle.
// Reset is synchronous, clears the sequencer and the accumulators and empties the result buffer.
// Results drain from a buffer while new requests are taken; a last residue waits only if
// the previous coefficient's results are still being read out.
// Depends on rfbe_pkg and rfbe_ram.
`timescale 1ns / 1ps
module rns_fast_base_extension
   import rfbe_pkg::*;
#(
   parameter int NUM_SOURCE   = 8,
   parameter int NUM_TARGET   = 4,
   parameter int MODULUS_BITS = 60
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [2:0] op, [5:3] source_index, [8:6] target_index, [68:9] value, [71:69] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] target_limb, [62:3] residue, [63] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int WORD_W    = (MODULUS_BITS < DATA_W) ? MODULUS_BITS : DATA_W;
   localparam int T_W       = WORD_W + 2;
   localparam int SRC_IW    = (NUM_SOURCE > 1) ? $clog2(NUM_SOURCE) : 1;
   localparam int TGT_IW    = (NUM_TARGET > 1) ? $clog2(NUM_TARGET) : 1;
   localparam int QMT_DEPTH = NUM_SOURCE * NUM_TARGET;
   localparam int QMT_AW    = (QMT_DEPTH > 1) ? $clog2(QMT_DEPTH) : 1;

   // Request fields.
   logic [OP_W-1:0]   req_op;
   logic [IDX_W-1:0]  req_si;
   logic [IDX_W-1:0]  req_ti;
   logic [DATA_W-1:0] req_value;
   logic [WORD_W-1:0] req_word;
   logic              req_fire;
   logic              req_src_ok;
   logic              req_tgt_ok;

   // Tables.
   logic [WORD_W-1:0] src_mod_ff  [NUM_SOURCE];
   logic [WORD_W-1:0] qhat_inv_ff [NUM_SOURCE];
   logic [WORD_W-1:0] tgt_mod_ff  [NUM_TARGET];
   logic [WORD_W-1:0] acc_ff      [NUM_TARGET];
   logic [WORD_W-1:0] out_buf_ff  [NUM_TARGET];
   logic              qmt_we;
   logic [QMT_AW-1:0] qmt_waddr;
   logic [QMT_AW-1:0] qmt_raddr;
   logic [WORD_W-1:0] qmt_rdata;

   // Sequencer and datapath registers.
   state_type         state_ff, state_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [WORD_W-1:0] r_ff, r_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] v_ff, v_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  si_ff;
   logic [DATA_W-1:0] val_ff;
   logic              last_ff;
   logic [TGT_IW-1:0] j_ff, j_in;
   logic              out_busy_ff, out_busy_in;
   logic [TGT_IW-1:0] out_idx_ff, out_idx_in;

   // Serial unit.
   logic              pass_active;
   logic              pass_done;
   logic [WORD_W-1:0] unit_mod;
   logic [WORD_W-1:0] unit_addend;
   logic [DATA_W-1:0] unit_opnd;
   logic              unit_bit;
   logic [T_W-1:0]    unit_t;
   logic [T_W-1:0]    unit_m1;
   logic [T_W-1:0]    unit_m2;
   logic [WORD_W-1:0] unit_res;
   logic [WORD_W-1:0] pass_res;
   logic [WORD_W:0]   add_sum;
   logic [WORD_W-1:0] add_res;
   logic              acc_we;
   logic              snap;
   logic              rsp_fire;
   logic [SRC_IW-1:0] sidx;
   logic              j_last;
   logic              out_last;

   assign req_op     = req_tdata[OP_W-1:0];
   assign req_si     = req_tdata[OP_W +: IDX_W];
   assign req_ti     = req_tdata[OP_W+IDX_W +: IDX_W];
   assign req_value  = req_tdata[OP_W+2*IDX_W +: DATA_W];
   assign req_word   = req_value[WORD_W-1:0];
   assign req_fire   = req_tvalid & req_tready;
   assign req_src_ok = {1'b0, req_si} < (IDX_W+1)'(NUM_SOURCE);
   assign req_tgt_ok = {1'b0, req_ti} < (IDX_W+1)'(NUM_TARGET);

   assign sidx     = si_ff[SRC_IW-1:0];
   assign j_last   = (j_ff == TGT_IW'(NUM_TARGET - 1));
   assign out_last = (out_idx_ff == TGT_IW'(NUM_TARGET - 1));
   assign rsp_fire = rsp_tvalid & rsp_tready;

   assign qmt_we    = req_fire && (req_op == OP_QHAT_TGT) && req_src_ok && req_tgt_ok;
   assign qmt_waddr = QMT_AW'(int'(req_si) * NUM_TARGET + int'(req_ti));
   assign qmt_raddr = QMT_AW'(int'(si_ff) * NUM_TARGET + int'(j_ff));

   rfbe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (QMT_DEPTH)
   ) u_qmt_ram (
      .clock (clock),
      .we    (qmt_we),
      .waddr (qmt_waddr),
      .wdata (req_word),
      .raddr (qmt_raddr),
      .rdata (qmt_rdata)
   );

   // Operand selection for the shared unit. A reduce pass streams a value in with an
   // addend of one; a multiply pass streams the multiplier against a reduced addend.
   always_comb begin
      pass_active = 1'b1;
      unit_mod    = tgt_mod_ff[j_ff];
      unit_addend = WORD_W'(1);
      unit_opnd   = '0;
      case (state_ff)
         ST_SRC_RED: begin
            unit_mod  = src_mod_ff[sidx];
            unit_opnd = val_ff;
         end
         ST_SRC_MUL: begin
            unit_mod    = src_mod_ff[sidx];
            unit_addend = a_ff;
            unit_opnd   = DATA_W'(qhat_inv_ff[sidx]);
         end
         ST_TGT_RED: begin
            unit_opnd = DATA_W'(v_ff);
         end
         ST_TGT_MUL: begin
            unit_addend = a_ff;
            unit_opnd   = DATA_W'(qmt_rdata);
         end
         ST_ACC_RED: begin
            unit_opnd = DATA_W'(acc_ff[j_ff]);
         end
         default: begin
            pass_active = 1'b0;
         end
      endcase
   end

   // One step: r <- (2r + bit*addend) mod m. The sum stays below 3m, so one of two
   // parallel subtractions finishes the reduction.
   always_comb begin
      unit_bit = unit_opnd[bit_ff];
      unit_t   = (T_W'(r_ff) << 1) + (unit_bit ? T_W'(unit_addend) : T_W'(0));
      unit_m1  = T_W'(unit_mod);
      unit_m2  = T_W'(unit_mod) << 1;
      if (unit_t >= unit_m2) begin
         unit_res = WORD_W'(unit_t - unit_m2);
      end else if (unit_t >= unit_m1) begin
         unit_res = WORD_W'(unit_t - unit_m1);
      end else begin
         unit_res = WORD_W'(unit_t);
      end
      pass_res  = (unit_mod == '0) ? '0 : unit_res;
      pass_done = pass_active && (bit_ff == '0);
   end

   // Final modular add of the reduced accumulator and the new product.
   always_comb begin
      add_sum = {1'b0, a_ff} + {1'b0, prod_ff};
      if (tgt_mod_ff[j_ff] == '0) begin
         add_res = '0;
      end else if (add_sum >= {1'b0, tgt_mod_ff[j_ff]}) begin
         add_res = WORD_W'(add_sum - {1'b0, tgt_mod_ff[j_ff]});
      end else begin
         add_res = WORD_W'(add_sum);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_RESIDUE)) begin
               state_in = req_src_ok ? ST_SRC_RED : ST_FINISH;
            end
         end
         ST_SRC_RED: if (pass_done) state_in = ST_SRC_MUL;
         ST_SRC_MUL: if (pass_done) state_in = ST_TGT_RED;
         ST_TGT_RED: if (pass_done) state_in = ST_TGT_MUL;
         ST_TGT_MUL: if (pass_done) state_in = ST_ACC_RED;
         ST_ACC_RED: if (pass_done) state_in = ST_ACC_ADD;
         ST_ACC_ADD: begin
            state_in = j_last ? ST_FINISH : ST_TGT_RED;
         end
         ST_FINISH: begin
            if (!last_ff || !out_busy_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      acc_we     = (state_ff == ST_ACC_ADD);
      snap       = (state_ff == ST_FINISH) && last_ff && !out_busy_ff;

      bit_in  = (pass_done || !pass_active) ? BIT_W'(DATA_W - 1) : bit_ff - BIT_W'(1);
      r_in    = (pass_done || !pass_active) ? '0 : unit_res;
      a_in    = a_ff;
      v_in    = v_ff;
      prod_in = prod_ff;
      j_in    = j_ff;
      if (pass_done) begin
         case (state_ff)
            ST_SRC_RED: a_in = pass_res;
            ST_SRC_MUL: begin
               v_in = pass_res;
               j_in = '0;
            end
            ST_TGT_RED: a_in    = pass_res;
            ST_TGT_MUL: prod_in = pass_res;
            ST_ACC_RED: a_in    = pass_res;
            default:    a_in    = a_ff;
         endcase
      end
      if (acc_we && !j_last) begin
         j_in = j_ff + TGT_IW'(1);
      end

      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      if (snap) begin
         out_busy_in = 1'b1;
         out_idx_in  = '0;
      end else if (rsp_fire) begin
         if (out_last) begin
            out_busy_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + TGT_IW'(1);
         end
      end

      rsp_tvalid = out_busy_ff;
      rsp_tlast  = out_last;
      rsp_tdata  = RSP_TDATA_W'({DATA_W'(out_buf_ff[out_idx_ff]), IDX_W'(out_idx_ff)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_busy_ff <= 1'b0;
         for (int k = 0; k < NUM_TARGET; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         out_busy_ff <= out_busy_in;
         if (snap) begin
            for (int k = 0; k < NUM_TARGET; k++) begin
               acc_ff[k] <= '0;
            end
         end else if (acc_we) begin
            acc_ff[j_ff] <= add_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff     <= bit_in;
      r_ff       <= r_in;
      a_ff       <= a_in;
      v_ff       <= v_in;
      prod_ff    <= prod_in;
      j_ff       <= j_in;
      out_idx_ff <= out_idx_in;
      if (req_fire && (req_op == OP_RESIDUE)) begin
         si_ff   <= req_si;
         val_ff  <= req_value;
         last_ff <= req_tlast;
      end
      if (req_fire && (req_op == OP_SRC_MOD) && req_src_ok) begin
         src_mod_ff[req_si[SRC_IW-1:0]] <= req_word;
      end
      if (req_fire && (req_op == OP_QHAT_INV) && req_src_ok) begin
         qhat_inv_ff[req_si[SRC_IW-1:0]] <= req_word;
      end
      if (req_fire && (req_op == OP_TGT_MOD) && req_tgt_ok) begin
         tgt_mod_ff[req_ti[TGT_IW-1:0]] <= req_word;
      end
      if (snap) begin
         for (int k = 0; k < NUM_TARGET; k++) begin
            out_buf_ff[k] <= acc_ff[k];
         end
      end
   end

   // A serial pass always ends fully reduced when its modulus is nonzero.
   a_pass_reduced: assert property (@(posedge clock) disable iff (reset)
      (pass_done && (unit_mod != '0)) |-> (unit_res < unit_mod))
      else $error("serial pass result not below its modulus");

   // The result buffer is only loaded from the finishing step of a last residue.
   a_buf_load: assert property (@(posedge clock) disable iff (reset)
      $rose(out_busy_ff) |-> ($past(state_ff) == ST_FINISH) && $past(last_ff))
      else $error("result buffer loaded outside the finishing step");

   // The final result of a coefficient empties the buffer.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> !rsp_tvalid)
      else $error("results continue past the last one");

   // The first accumulator starts from zero after a coefficient is handed off.
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      snap |=> (acc_ff[0] == '0))
      else $error("accumulator not cleared after hand-off");

endmodule

/* sim/tb_rns_fast_base_extension.sv */
// Self-checking testbench for rns_fast_base_extension: loads the limb tables, sends residue
// requests and compares every extended residue against a predictor kept in step with it.
// Depends on rfbe_pkg and the RTL of rns_fast_base_extension, which uses rfbe_ram.
`timescale 1ns / 1ps
module tb_rns_fast_base_extension;
   import rfbe_pkg::*;

   localparam int NUM_SOURCE      = 8;
   localparam int NUM_TARGET      = 4;
   localparam int TGT_IW          = (NUM_TARGET > 1) ? $clog2(NUM_TARGET) : 1;
   localparam int RESIDUE_CYCLES  = 122 + 181 * NUM_TARGET;
   localparam int RANDOM_REQUESTS = 150;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int MAX_INDEX       = (1 << IDX_W) - 1;
   localparam int REQ_PAD_W       = REQ_TDATA_W - OP_W - 2 * IDX_W - DATA_W;

   localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0]   OP_UNUSED_LAST  = 3'd7;
   localparam logic [DATA_W-1:0] WORD_MAX        = '1;

   typedef struct packed {
      logic [IDX_W-1:0]  limb;
      logic [DATA_W-1:0] residue;
      logic              last;
   } limb_residue_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // Predictor state: the limb tables and the running sums of the coefficient.
   logic [DATA_W-1:0] source_moduli [NUM_SOURCE] = '{default: '0};
   logic [DATA_W-1:0] target_moduli [NUM_TARGET] = '{default: '0};
   logic [DATA_W-1:0] qhat_inverses [NUM_SOURCE] = '{default: '0};
   logic [DATA_W-1:0] qhat_targets  [NUM_SOURCE][NUM_TARGET] = '{default: '{default: '0}};
   logic [DATA_W-1:0] limb_sums     [NUM_TARGET] = '{default: '0};

   limb_residue_type pending_residues[$];

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  sink_hold   = 0;
   bit  sender_idle = 1'b1;
   bit  sink_idle   = 1'b1;

   rns_fast_base_extension #(
      .NUM_SOURCE  (NUM_SOURCE),
      .NUM_TARGET  (NUM_TARGET),
      .MODULUS_BITS(DATA_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] mul_mod(input logic [DATA_W-1:0] a, b, m);
      logic [2*DATA_W-1:0] wide_a, wide_b, wide_m, prod;
      if (m == '0) return '0;
      wide_a = a;
      wide_b = b;
      wide_m = m;
      prod   = ((wide_a % wide_m) * (wide_b % wide_m)) % wide_m;
      return prod[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a, b, m);
      logic [DATA_W:0] wide_m, sum;
      if (m == '0) return '0;
      wide_m = m;
      sum    = ({1'b0, a} % wide_m) + ({1'b0, b} % wide_m);
      if (sum >= wide_m) sum = sum - wide_m;
      return sum[DATA_W-1:0];
   endfunction

   // Applies one accepted request to the predictor and queues the residues it yields.
   function automatic void predict_extension(input logic [OP_W-1:0] op,
                                             input logic [IDX_W-1:0] src, tgt,
                                             input logic [DATA_W-1:0] value,
                                             input logic last);
      logic [DATA_W-1:0] scaled, term;
      limb_residue_type  result;
      int                j;
      case (op)
         OP_SRC_MOD: if (src < NUM_SOURCE) source_moduli[src] = value;
         OP_TGT_MOD: if (tgt < NUM_TARGET) target_moduli[tgt[TGT_IW-1:0]] = value;
         OP_QHAT_INV: if (src < NUM_SOURCE) qhat_inverses[src] = value;
         OP_QHAT_TGT: begin
            if (src < NUM_SOURCE && tgt < NUM_TARGET)
               qhat_targets[src][tgt[TGT_IW-1:0]] = value;
         end
         OP_RESIDUE: begin
            if (src < NUM_SOURCE) begin
               scaled = mul_mod(value, qhat_inverses[src], source_moduli[src]);
               for (j = 0; j < NUM_TARGET; j++) begin
                  term         = mul_mod(scaled, qhat_targets[src][j], target_moduli[j]);
                  limb_sums[j] = add_mod(limb_sums[j], term, target_moduli[j]);
               end
            end
            if (last) begin
               for (j = 0; j < NUM_TARGET; j++) begin
                  result.limb    = j[IDX_W-1:0];
                  result.residue = limb_sums[j];
                  result.last    = (j == NUM_TARGET - 1);
                  pending_residues.insert(pending_residues.size(), result);
                  limb_sums[j] = '0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      limb_residue_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_residues.size() == 0) begin
            report_mismatch($sformatf("unexpected result tdata=%h tlast=%b", rsp_tdata,
                                      rsp_tlast));
         end else begin
            want = pending_residues.pop_front();
            if (rsp_tdata[IDX_W-1:0] != want.limb ||
                rsp_tdata[IDX_W +: DATA_W] != want.residue ||
                rsp_tdata[RSP_TDATA_W-1:IDX_W+DATA_W] != '0 ||
                rsp_tlast != want.last)
               report_mismatch($sformatf("limb %0d/%0d residue %h/%h last %b/%b pad %h",
                                         want.limb, rsp_tdata[IDX_W-1:0], want.residue,
                                         rsp_tdata[IDX_W +: DATA_W], want.last, rsp_tlast,
                                         rsp_tdata[RSP_TDATA_W-1:IDX_W+DATA_W]));
         end
      end
   end

   // Result side: a long hold when asked for, otherwise random stall bursts while sink_idle is set.
   initial begin : result_sink
      int hold_len;
      forever begin
         if (sink_hold > 0) begin
            hold_len  = sink_hold;
            sink_hold = 0;
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
         end else if (sink_idle && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [DATA_W-1:0] random_word();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[DATA_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] random_index(input int lo, hi);
      logic [31:0] pick;
      pick = $urandom_range(lo, hi);
      return pick[IDX_W-1:0];
   endfunction

   // Mostly full-width words, with the extremes and small values mixed in.
   function automatic logic [DATA_W-1:0] random_operand();
      logic [31:0] small_word;
      small_word = $urandom_range(2, 65535);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WORD_MAX;
         2: return {{(DATA_W-32){1'b0}}, small_word};
         default: return random_word();
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] src, tgt,
                               input logic [DATA_W-1:0] value, input logic last);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, value, tgt, src, op};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_extension(op, src, tgt, value, last);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
   endtask

   task automatic send_coefficient(input int limbs, input bit in_order);
      int n;
      for (n = 0; n < limbs; n++)
         send_request(OP_RESIDUE,
                      in_order ? random_index(n, n) : random_index(0, NUM_SOURCE - 1),
                      random_index(0, MAX_INDEX), random_operand(), n == limbs - 1);
   endtask

   // Writes every table entry, so that no residue ever reads an unwritten word.
   task automatic load_tables();
      int i, j;
      for (i = 0; i < NUM_SOURCE; i++) begin
         send_request(OP_SRC_MOD, random_index(i, i), random_index(0, MAX_INDEX),
                      random_operand(), 1'($urandom_range(0, 1)));
         send_request(OP_QHAT_INV, random_index(i, i), random_index(0, MAX_INDEX),
                      random_operand(), 1'($urandom_range(0, 1)));
      end
      for (j = 0; j < NUM_TARGET; j++)
         send_request(OP_TGT_MOD, random_index(0, MAX_INDEX), random_index(j, j),
                      random_operand(), 1'($urandom_range(0, 1)));
      for (i = 0; i < NUM_SOURCE; i++)
         for (j = 0; j < NUM_TARGET; j++)
            send_request(OP_QHAT_TGT, random_index(i, i), random_index(j, j),
                         random_operand(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_corner_cases();
      logic [31:0] code;
      // Largest modulus with operands at and just below it; last on a write is ignored.
      send_request(OP_SRC_MOD, 3'd0, 3'd0, WORD_MAX, 1'b0);
      send_request(OP_QHAT_INV, 3'd0, 3'd0, WORD_MAX - 1, 1'b1);
      send_request(OP_TGT_MOD, 3'd0, 3'd0, WORD_MAX, 1'b0);
      send_request(OP_TGT_MOD, 3'd0, 3'd1, '0, 1'b0);
      send_request(OP_TGT_MOD, 3'd0, 3'd2, 60'd1, 1'b0);
      send_request(OP_QHAT_TGT, 3'd0, 3'd0, WORD_MAX - 1, 1'b0);
      // The largest table word must still be reduced by its target modulus.
      send_request(OP_QHAT_TGT, 3'd0, 3'd3, WORD_MAX, 1'b0);
      send_request(OP_RESIDUE, 3'd0, 3'd0, WORD_MAX, 1'b0);
      send_request(OP_RESIDUE, 3'd0, 3'd7, WORD_MAX - 1, 1'b0);
      send_request(OP_RESIDUE, 3'd0, 3'd0, '0, 1'b1);
      // A zero source modulus contributes nothing.
      send_request(OP_SRC_MOD, 3'd1, 3'd0, '0, 1'b0);
      send_request(OP_RESIDUE, 3'd1, 3'd0, random_word(), 1'b1);
      // Unused codes, even with last set, must produce no result.
      for (code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
         send_request(code[OP_W-1:0], 3'd7, 3'd7, WORD_MAX, 1'b1);
      // Target indexes past the table are dropped; the residue after them shows any alias.
      for (code = NUM_TARGET; code <= MAX_INDEX; code++)
         send_request(OP_TGT_MOD, 3'd2, code[IDX_W-1:0], '0, 1'b0);
      send_request(OP_QHAT_TGT, 3'd2, 3'd5, '0, 1'b0);
      send_request(OP_RESIDUE, 3'd2, 3'd0, random_word(), 1'b1);
      load_tables();
   endtask

   task automatic test_random_coefficients();
      int sent, limbs;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         sink_idle   = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               limbs = $urandom_range(1, NUM_SOURCE);
               send_coefficient(limbs, 1'($urandom_range(0, 1)));
               sent += limbs;
            end
            7, 8: begin
               send_request(OP_W'(OP_SRC_MOD + $urandom_range(0, OP_QHAT_TGT - OP_SRC_MOD)),
                            random_index(0, MAX_INDEX), random_index(0, MAX_INDEX),
                            random_operand(), 1'($urandom_range(0, 1)));
               sent++;
            end
            default: begin
               send_request(OP_W'(OP_UNUSED_FIRST +
                                  $urandom_range(0, OP_UNUSED_LAST - OP_UNUSED_FIRST)),
                            random_index(0, MAX_INDEX), random_index(0, MAX_INDEX),
                            random_word(), 1'($urandom_range(0, 1)));
               sent++;
            end
         endcase
      end
      sender_idle = 1'b1;
      sink_idle   = 1'b1;
   endtask

   // The result side stops long enough for the block to fill and hold off requests.
   task automatic test_result_backpressure();
      int n;
      sender_idle = 1'b0;
      sink_hold   = 5 * RESIDUE_CYCLES;
      for (n = 0; n < 4; n++)
         send_request(OP_RESIDUE, random_index(0, NUM_SOURCE - 1), random_index(0, MAX_INDEX),
                      random_operand(), 1'b1);
      wait_for_results();
      sender_idle = 1'b1;
   endtask

   task automatic test_back_to_back();
      int n;
      sender_idle = 1'b0;
      sink_idle   = 1'b0;
      for (n = 0; n < 3; n++)
         send_coefficient(NUM_SOURCE, 1'b1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_tables();
      test_corner_cases();
      test_random_coefficients();
      test_result_backpressure();
      test_back_to_back();
      wait_for_results();
      repeat (RESIDUE_CYCLES + 32) @(posedge clock);
      if (mismatches == 0 && pending_residues.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
